FILE: design/speech_bubble_alpha_mask_top_defines.svh
// Assertion macros for the speech bubble alpha mask block.
`ifndef SPEECH_BUBBLE_ALPHA_MASK_TOP_DEFINES_SVH
`define SPEECH_BUBBLE_ALPHA_MASK_TOP_DEFINES_SVH

// same-cycle implication
`define SBAM_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("sbam: assertion failed");

// next-cycle implication
`define SBAM_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("sbam: assertion failed");

`endif

FILE: design/sbam_pkg.sv
// Package: constants, widths and types of the speech bubble alpha mask.
package sbam_pkg;

    localparam int FRAC       = 16;
    localparam int SPA        = 3;
    localparam int GRID_N     = SPA * SPA;
    localparam int CUBE_MAX   = GRID_N * GRID_N * GRID_N;
    localparam int KW         = $clog2(GRID_N + 1);
    localparam int K3W        = $clog2(CUBE_MAX + 1);

    localparam longint ONE     = longint'(1) << FRAC;
    localparam longint HALF    = ONE / 2;
    localparam longint QUARTER = ONE / 4;
    localparam longint TRI_X0  = (1 * ONE + 5) / 10;
    localparam longint TRI_X1  = (3 * ONE + 5) / 10;
    localparam longint TRI_X2  = (4 * ONE + 5) / 10;
    localparam longint TRI_Y2  = (2 * ONE + 5) / 10;

    localparam int CW    = 16;
    localparam int PW    = 18;
    localparam int EW    = 40;
    localparam int DXW   = 18;
    localparam int DYW   = 17;
    localparam int DX2W  = 31;
    localparam int SQW   = 34;
    localparam int ROOTW = SQW / 2;
    localparam int RMW   = ROOTW + 4;
    localparam int MW    = FRAC + 1;
    localparam int M2W   = MW + 8;
    localparam int PRW   = MW + K3W;
    localparam int XW    = PRW + 8 - FRAC;

    localparam int     R9_SH     = 34;
    localparam longint R9_RCP    = ((longint'(1) << R9_SH) + 8) / 9;
    localparam int     R9W       = 31;
    localparam int     AL_SH     = 28;
    localparam longint AL_RCP    = ((longint'(1) << AL_SH) + CUBE_MAX - 1) / CUBE_MAX;
    localparam int     ALW       = 20;
    localparam int     RAMP_GAIN = 200;

    localparam logic [1:0] CFG_STEP_X = 2'd0;
    localparam logic [1:0] CFG_STEP_Y = 2'd1;

    localparam logic [CW-1:0] STEP_RESET = CW'(64);

    typedef struct packed {
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
        logic [KW-1:0] k;
    } t_side;

endpackage

FILE: design/speech_bubble_alpha_mask_top.sv
// Top level: speech bubble alpha mask, fully pipelined pixel datapath.
// o_strobe marks each result of a start beat, which passes through 25 register
// stages: 4 geometry, 17 square-root, 4 alpha. Throughput: one pixel per cycle.
// busy stays low and o_cfg_ready stays high; results cannot be stalled.
// Synchronous active-low reset clears valid bits and sets both steps to 64.
`include "speech_bubble_alpha_mask_top_defines.svh"

module speech_bubble_alpha_mask_top
    import sbam_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [7:0]    i_red_in,
    input  logic [7:0]    i_green_in,
    input  logic [7:0]    i_blue_in,
    input  logic [CW-1:0] i_pos_x,
    input  logic [CW-1:0] i_pos_y,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [CW-1:0] i_cfg_data,
    output logic          o_strobe,
    output logic [7:0]    o_red_out,
    output logic [7:0]    o_green_out,
    output logic [7:0]    o_blue_out,
    output logic [7:0]    o_alpha_out
);

    localparam logic signed [EW-1:0] C_X0   = EW'(TRI_X0);
    localparam logic signed [EW-1:0] C_X1   = EW'(TRI_X1);
    localparam logic signed [EW-1:0] C_X2   = EW'(TRI_X2);
    localparam logic signed [EW-1:0] C_Y2   = EW'(TRI_Y2);
    localparam logic signed [EW-1:0] K_S_PX = C_Y2;
    localparam logic signed [EW-1:0] K_S_PY = C_X0 - C_X2;
    localparam logic signed [EW-1:0] K_T_PY = C_X1 - C_X0;
    localparam logic signed [EW-1:0] K_E_PY = C_X2 - C_X1;
    localparam logic signed [EW-1:0] K_E_PX = C_Y2;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration
    logic [CW-1:0] r_step_x, r_step_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x <= STEP_RESET;
            r_step_y <= STEP_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_STEP_X) r_step_x <= i_cfg_data;
            if (i_cfg_index == CFG_STEP_Y) r_step_y <= i_cfg_data;
        end
    end

    // stage 1: subsample coordinates, distance offsets
    logic                  r_v1;
    t_side                 r_sd1;
    logic [PW-1:0]         r_px [SPA];
    logic [PW-1:0]         r_py [SPA];
    logic signed [DXW-1:0] r_dx;
    logic [DYW-1:0]        r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= start;
    end

    always_ff @(posedge i_clk) begin
        r_sd1 <= '{red: i_red_in, green: i_green_in, blue: i_blue_in, k: '0};
        r_dx  <= DXW'(HALF) - DXW'(i_pos_x);
        r_dy  <= DYW'(TRI_Y2) + DYW'(i_pos_y);
    end

    for (genvar i = 0; i < SPA; i++) begin : g_coord
        always_ff @(posedge i_clk) begin
            r_px[i] <= PW'(i_pos_x) + PW'(i * r_step_x);
            r_py[i] <= PW'(i_pos_y) + PW'(i * r_step_y);
        end
    end

    // stage 2: per-axis edge products, squares
    logic                 r_v2;
    t_side                r_sd2;
    logic signed [EW-1:0] r_sa [SPA];
    logic signed [EW-1:0] r_sb [SPA];
    logic signed [EW-1:0] r_tc [SPA];
    logic signed [EW-1:0] r_ef [SPA];
    logic signed [EW-1:0] r_eg [SPA];
    logic [DX2W-1:0]      r_dx2;
    logic [SQW-1:0]       r_dy2;
    logic signed [2*DXW-1:0] n_dxsq;
    logic [2*DYW-1:0]        n_dysq;

    assign n_dxsq = r_dx * r_dx;
    assign n_dysq = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        r_sd2 <= r_sd1;
        r_dx2 <= n_dxsq[DX2W-1:0];
        r_dy2 <= SQW'(n_dysq);
    end

    for (genvar i = 0; i < SPA; i++) begin : g_prod
        logic signed [EW-1:0] n_pxs, n_pys;
        assign n_pxs = $signed({{(EW-PW){1'b0}}, r_px[i]});
        assign n_pys = $signed({{(EW-PW){1'b0}}, r_py[i]});
        always_ff @(posedge i_clk) begin
            r_sa[i] <= K_S_PX * (n_pxs - C_X2);
            r_sb[i] <= K_S_PY * (n_pys - C_Y2);
            r_tc[i] <= K_T_PY * n_pys;
            r_ef[i] <= K_E_PY * n_pys;
            r_eg[i] <= K_E_PX * (n_pxs - C_X1);
        end
    end

    // stage 3: point-in-triangle per subsample, divide-by-9 product
    logic                        r_v3;
    t_side                       r_sd3;
    logic [GRID_N-1:0]           r_outs;
    logic [DX2W+R9W-1:0]         r_q9;
    logic [SQW-1:0]              r_dy2b;
    logic [GRID_N-1:0]           n_outs;

    for (genvar i = 0; i < SPA; i++) begin : g_tri_i
        for (genvar j = 0; j < SPA; j++) begin : g_tri_j
            logic signed [EW-1:0] n_s, n_t, n_e, n_st;
            logic                 n_diff, n_in;
            assign n_s    = r_sa[i] + r_sb[j];
            assign n_t    = r_tc[j];
            assign n_e    = r_ef[j] - r_eg[i];
            assign n_st   = n_s + n_t;
            assign n_diff = ((n_s < 0) != (n_t < 0)) && (n_s != 0) && (n_t != 0);
            assign n_in   = (n_e == 0) || ((n_e < 0) == (n_st <= 0));
            assign n_outs[i*SPA+j] = n_diff || !n_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        r_sd3  <= r_sd2;
        r_outs <= n_outs;
        r_q9   <= r_dx2 * R9W'(R9_RCP);
        r_dy2b <= r_dy2;
    end

    // stage 4: coverage count, radicand
    logic           r_v4;
    t_side          r_sd4;
    logic [SQW-1:0] r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        r_sd4 <= '{red: r_sd3.red, green: r_sd3.green, blue: r_sd3.blue,
                   k: KW'($countones(r_outs))};
        r_sq  <= r_dy2b + SQW'(r_q9 >> R9_SH);
    end

    // square root, one result bit per stage
    logic              r_qv   [1:ROOTW];
    t_side             r_qsd  [1:ROOTW];
    logic [SQW-1:0]    r_qval [1:ROOTW];
    logic [RMW-1:0]    r_qrem [1:ROOTW];
    logic [ROOTW-1:0]  r_qrt  [1:ROOTW];

    for (genvar n = 0; n < ROOTW; n++) begin : g_sqrt
        logic             n_v;
        t_side            n_sd;
        logic [SQW-1:0]   n_val;
        logic [RMW-1:0]   n_rem, n_cand, n_trial;
        logic [ROOTW-1:0] n_rt;
        if (n == 0) begin : g_head
            assign n_v   = r_v4;
            assign n_sd  = r_sd4;
            assign n_val = r_sq;
            assign n_rem = '0;
            assign n_rt  = '0;
        end else begin : g_body
            assign n_v   = r_qv[n];
            assign n_sd  = r_qsd[n];
            assign n_val = r_qval[n];
            assign n_rem = r_qrem[n];
            assign n_rt  = r_qrt[n];
        end
        assign n_cand  = {n_rem[RMW-3:0], n_val[SQW-1-2*n -: 2]};
        assign n_trial = RMW'({n_rt, 2'b01});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_qv[n+1] <= 1'b0;
            else          r_qv[n+1] <= n_v;
        end
        always_ff @(posedge i_clk) begin
            r_qsd[n+1]  <= n_sd;
            r_qval[n+1] <= n_val;
            if (n_cand >= n_trial) begin
                r_qrem[n+1] <= n_cand - n_trial;
                r_qrt[n+1]  <= {n_rt[ROOTW-2:0], 1'b1};
            end else begin
                r_qrem[n+1] <= n_cand;
                r_qrt[n+1]  <= {n_rt[ROOTW-2:0], 1'b0};
            end
        end
    end

    // alpha 1: ramp and cube
    logic             r_a1v;
    t_side            r_a1sd;
    logic [MW-1:0]    r_m;
    logic [K3W-1:0]   r_k3;
    logic [ROOTW-1:0] n_d;
    logic [M2W-1:0]   n_m200;
    logic [MW-1:0]    n_m;
    logic [K3W-1:0]   n_kw;

    assign n_d  = r_qrt[ROOTW];
    assign n_kw = K3W'(r_qsd[ROOTW].k);

    always_comb begin
        n_m200 = M2W'(n_d - ROOTW'(QUARTER)) * M2W'(RAMP_GAIN);
        if (n_d < ROOTW'(QUARTER))      n_m = '0;
        else if (n_m200 > M2W'(ONE))    n_m = MW'(ONE);
        else                            n_m = n_m200[MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a1v <= 1'b0;
        else          r_a1v <= r_qv[ROOTW];
    end

    always_ff @(posedge i_clk) begin
        r_a1sd <= r_qsd[ROOTW];
        r_m    <= n_m;
        r_k3   <= n_kw * n_kw * n_kw;
    end

    // alpha 2: ramp times cube
    logic           r_a2v;
    t_side          r_a2sd;
    logic [PRW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a2v <= 1'b0;
        else          r_a2v <= r_a1v;
    end

    always_ff @(posedge i_clk) begin
        r_a2sd <= r_a1sd;
        r_p    <= PRW'(r_m) * PRW'(r_k3);
    end

    // alpha 3: scale by 255, drop fraction
    logic           r_a3v;
    t_side          r_a3sd;
    logic [XW-1:0]  r_x;
    logic [PRW+7:0] n_x255;

    assign n_x255 = {r_p, 8'b0} - (PRW+8)'(r_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a3v <= 1'b0;
        else          r_a3v <= r_a2v;
    end

    always_ff @(posedge i_clk) begin
        r_a3sd <= r_a2sd;
        r_x    <= XW'(n_x255 >> FRAC);
    end

    // alpha 4: divide by grid cube, output register
    logic               r_ov;
    t_side              r_osd;
    logic [7:0]         r_alpha;
    logic [XW+ALW-1:0]  n_ad;

    assign n_ad = r_x * ALW'(AL_RCP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else          r_ov <= r_a3v;
    end

    always_ff @(posedge i_clk) begin
        r_osd   <= r_a3sd;
        r_alpha <= 8'(n_ad >> AL_SH);
    end

    assign o_strobe    = r_ov;
    assign o_red_out   = r_osd.red;
    assign o_green_out = r_osd.green;
    assign o_blue_out  = r_osd.blue;
    assign o_alpha_out = r_alpha;

    `SBAM_ASSERT_NXT(a_cfg_x, i_cfg_valid && i_cfg_index == CFG_STEP_X, r_step_x == $past(i_cfg_data))
    `SBAM_ASSERT_NXT(a_ramp_zero, r_qv[ROOTW] && n_d < ROOTW'(QUARTER), r_m == '0)
    `SBAM_ASSERT_IMP(a_k_zero, r_ov && r_osd.k == '0, r_alpha == 8'd0)

endmodule
